@@ hdl/ryuv_pkg.sv @@
package ryuv_pkg;

  // configuration port
  localparam int PADDR_W    = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_W      = 13;

  localparam logic [PADDR_W-1:0] ADDR_FRAME_WIDTH  = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_FRAME_HEIGHT = 3'd4;

  localparam logic [REG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [REG_W-1:0] FRAME_HEIGHT_RST = 13'd480;
  localparam logic [REG_W-1:0] HEIGHT_LIMIT     = 13'd4096;

  // pixel and sample widths
  localparam int PIX_W  = 8;
  localparam int ROW_W  = 12;
  localparam int COMP_W = 9;
  localparam int PAIR_W = 3 * COMP_W;

  // luma coefficients
  localparam logic [15:0] Y_R      = 16'd66;
  localparam logic [15:0] Y_G      = 16'd129;
  localparam logic [15:0] Y_B      = 16'd25;
  localparam logic [15:0] ROUND    = 16'd128;
  localparam logic [7:0]  Y_OFFSET = 8'd16;

  // chroma coefficients, magnitudes
  localparam logic signed [17:0] CB_R   = 18'sd38;
  localparam logic signed [17:0] CB_G   = 18'sd74;
  localparam logic signed [17:0] CB_B   = 18'sd112;
  localparam logic signed [17:0] CR_R   = 18'sd112;
  localparam logic signed [17:0] CR_G   = 18'sd94;
  localparam logic signed [17:0] CR_B   = 18'sd18;
  localparam logic signed [17:0] C_RND  = 18'sd128;
  localparam logic [7:0]         C_OFFSET = 8'd128;

endpackage

@@ hdl/ryuv_pix_if.sv @@
interface ryuv_pix_if;
  logic                           valid;
  logic                           ready;
  logic [ryuv_pkg::PIX_W-1:0]     red;
  logic [ryuv_pkg::PIX_W-1:0]     green;
  logic [ryuv_pkg::PIX_W-1:0]     blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

@@ hdl/ryuv_yuv_if.sv @@
interface ryuv_yuv_if;
  logic                           valid;
  logic                           ready;
  logic [ryuv_pkg::PIX_W-1:0]     luma;
  logic                           chroma_valid;
  logic [ryuv_pkg::PIX_W-1:0]     blue_diff;
  logic [ryuv_pkg::PIX_W-1:0]     red_diff;
  logic                           frame_end;

  modport source (output valid, output luma, output chroma_valid, output blue_diff,
                  output red_diff, output frame_end, input ready);
  modport sink   (input valid, input luma, input chroma_valid, input blue_diff,
                  input red_diff, input frame_end, output ready);
endinterface

@@ hdl/ryuv_ram.sv @@
module ryuv_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/rgb_to_yuv420_converter.sv @@
// An accepted pixel is registered in stage 1 while the line store read
// completes, then in the output register that drives the output ports.
// Throughput: one pixel per clock; the two stages are set by the registered
// read port of the line store. A stalled output holds the pipeline.
// Reset (rst_n low, synchronous): counters, pair hold and valid flags clear,
// frame_width = 640, frame_height = 480. The line store has no clearing pass.
module rgb_to_yuv420_converter #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  ryuv_pix_if.sink                          in_pix,
  ryuv_yuv_if.source                        out_yuv,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [ryuv_pkg::PADDR_W-1:0]      cfg_paddr,
  input  logic [ryuv_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [ryuv_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  localparam int CW    = $clog2(MAX_WIDTH);        // column counter
  localparam int WW    = $clog2(MAX_WIDTH + 1);    // holds MAX_WIDTH itself
  localparam int DEPTH = MAX_WIDTH / 2;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = ryuv_pkg::REG_W;
  localparam int CMW   = ryuv_pkg::COMP_W;
  localparam int PW    = ryuv_pkg::PIX_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [RW-1:0] frame_width_r;
  logic [RW-1:0] frame_height_r;
  logic          cfg_wr;
  logic          cfg_wr_w;
  logic          cfg_wr_h;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_wr_w   = cfg_wr && (cfg_paddr == ryuv_pkg::ADDR_FRAME_WIDTH);
  assign cfg_wr_h   = cfg_wr && (cfg_paddr == ryuv_pkg::ADDR_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= ryuv_pkg::FRAME_WIDTH_RST;
      frame_height_r <= ryuv_pkg::FRAME_HEIGHT_RST;
    end else begin
      if (cfg_wr_w) begin
        frame_width_r <= cfg_pwdata[RW-1:0];
      end
      if (cfg_wr_h) begin
        frame_height_r <= cfg_pwdata[RW-1:0];
      end
    end
  end

  always_comb begin
    unique case (cfg_paddr)
      ryuv_pkg::ADDR_FRAME_WIDTH:
        cfg_prdata = {{(ryuv_pkg::CFG_DATA_W-RW){1'b0}}, frame_width_r};
      ryuv_pkg::ADDR_FRAME_HEIGHT:
        cfg_prdata = {{(ryuv_pkg::CFG_DATA_W-RW){1'b0}}, frame_height_r};
      default:
        cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Effective and cropped frame size
  // ---------------------------------------------------------------------------
  logic [WW-1:0] eff_w;
  logic [WW-1:0] crop_w;
  logic [RW-1:0] eff_h;
  logic [RW-1:0] crop_h;

  always_comb begin
    // zero counts as one, oversize saturates
    if (frame_width_r == '0) begin
      eff_w = WW'(1);
    end else if ({1'b0, frame_width_r} > (RW+1)'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      eff_h = RW'(1);
    end else if (frame_height_r > ryuv_pkg::HEIGHT_LIMIT) begin
      eff_h = ryuv_pkg::HEIGHT_LIMIT;
    end else begin
      eff_h = frame_height_r;
    end
    crop_w = eff_w & ~WW'(1);
    crop_h = eff_h & ~RW'(1);
  end

  // ---------------------------------------------------------------------------
  // Input side: position counters, pair hold, line store access
  // ---------------------------------------------------------------------------
  logic [CW-1:0]                 col_r, col_nxt;
  logic [ryuv_pkg::ROW_W-1:0]    row_r, row_nxt;
  logic [ryuv_pkg::PAIR_W-1:0]   pair_hold_r;
  logic                          in_acc;
  logic                          keep;
  logic                          col_odd;
  logic                          row_odd;
  logic                          last_px;
  logic [WW-1:0]                 col_ext;
  logic [WW-1:0]                 col_inc;
  logic [RW-1:0]                 row_ext;
  logic [RW-1:0]                 row_inc;
  logic [CW-1:0]                 col_half;
  logic [AW-1:0]                 line_idx;
  logic [CMW-1:0]                pr, pg, pb;
  logic [ryuv_pkg::PAIR_W-1:0]   pair_sum;
  logic                          line_wr;
  logic                          line_rd;
  logic [ryuv_pkg::PAIR_W-1:0]   line_q;
  logic                          adv;

  assign in_acc   = in_pix.valid && in_pix.ready;
  assign col_ext  = WW'(col_r);
  assign row_ext  = RW'(row_r);
  assign keep     = (col_ext < crop_w) && (row_ext < crop_h);
  assign col_odd  = col_r[0];
  assign row_odd  = row_r[0];
  assign last_px  = (col_ext == crop_w - WW'(1)) && (row_ext == crop_h - RW'(1));
  assign col_half = col_r >> 1;
  assign line_idx = col_half[AW-1:0];

  // add the held even-column pixel to this one, component by component
  assign pr       = pair_hold_r[CMW-1:0]       + CMW'(in_pix.red);
  assign pg       = pair_hold_r[2*CMW-1:CMW]   + CMW'(in_pix.green);
  assign pb       = pair_hold_r[3*CMW-1:2*CMW] + CMW'(in_pix.blue);
  assign pair_sum = {pb, pg, pr};

  // even rows store the pair, odd rows fetch the pair above
  assign line_wr  = in_acc && keep && col_odd && !row_odd;
  assign line_rd  = in_acc && keep && col_odd && row_odd;

  always_comb begin
    col_inc = col_ext + WW'(1);
    row_inc = row_ext + RW'(1);
    col_nxt = col_r;
    row_nxt = row_r;
    if (col_inc >= eff_w) begin
      col_nxt = '0;
      if (row_inc >= eff_h) begin
        row_nxt = '0;
      end else begin
        row_nxt = row_inc[ryuv_pkg::ROW_W-1:0];
      end
    end else begin
      col_nxt = col_inc[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      pair_hold_r <= '0;
    end else if (cfg_wr_w || cfg_wr_h) begin
      // restart the frame
      col_r       <= '0;
      row_r       <= '0;
      pair_hold_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (keep && !col_odd) begin
        pair_hold_r <= {CMW'(in_pix.blue), CMW'(in_pix.green), CMW'(in_pix.red)};
      end
    end
  end

  ryuv_ram #(
    .WIDTH (ryuv_pkg::PAIR_W),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (line_wr),
    .wr_addr (line_idx),
    .wr_data (pair_sum),
    .rd_en   (line_rd),
    .rd_addr (line_idx),
    .rd_data (line_q)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: hold the pixel while the line store answers
  // ---------------------------------------------------------------------------
  logic                          s1_v_r;
  logic                          s1_chroma_r;
  logic                          s1_end_r;
  logic [PW-1:0]                 s1_red_r, s1_green_r, s1_blue_r;
  logic [ryuv_pkg::PAIR_W-1:0]   s1_pair_r;
  logic                          out_v_r;

  assign adv          = !out_v_r || out_yuv.ready;
  assign in_pix.ready = !s1_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_pix.ready) begin
      s1_v_r <= in_acc && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_chroma_r <= col_odd && row_odd;
      s1_end_r    <= last_px;
      s1_red_r    <= in_pix.red;
      s1_green_r  <= in_pix.green;
      s1_blue_r   <= in_pix.blue;
      s1_pair_r   <= pair_sum;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: luma, block average, chroma
  // ---------------------------------------------------------------------------
  logic [15:0]          y_sum;
  logic [PW-1:0]        y_val;
  logic [CMW:0]         qr, qg, qb;
  logic [PW-1:0]        ar, ag, ab;
  logic signed [17:0]   sr, sg, sb;
  logic signed [17:0]   cb_sum, cr_sum;
  logic signed [17:0]   cb_sh, cr_sh;
  logic [PW-1:0]        cb_val, cr_val;

  always_comb begin
    y_sum = ryuv_pkg::Y_R * 16'(s1_red_r) + ryuv_pkg::Y_G * 16'(s1_green_r)
          + ryuv_pkg::Y_B * 16'(s1_blue_r) + ryuv_pkg::ROUND;
    y_val = y_sum[15:8] + ryuv_pkg::Y_OFFSET;

    // four-pixel sum, truncated to the average
    qr = (CMW+1)'(s1_pair_r[CMW-1:0])       + (CMW+1)'(line_q[CMW-1:0]);
    qg = (CMW+1)'(s1_pair_r[2*CMW-1:CMW])   + (CMW+1)'(line_q[2*CMW-1:CMW]);
    qb = (CMW+1)'(s1_pair_r[3*CMW-1:2*CMW]) + (CMW+1)'(line_q[3*CMW-1:2*CMW]);
    ar = qr[CMW:2];
    ag = qg[CMW:2];
    ab = qb[CMW:2];
    sr = $signed({10'd0, ar});
    sg = $signed({10'd0, ag});
    sb = $signed({10'd0, ab});

    cb_sum = ryuv_pkg::CB_B * sb - ryuv_pkg::CB_R * sr - ryuv_pkg::CB_G * sg
           + ryuv_pkg::C_RND;
    cr_sum = ryuv_pkg::CR_R * sr - ryuv_pkg::CR_G * sg - ryuv_pkg::CR_B * sb
           + ryuv_pkg::C_RND;
    // arithmetic shift floors negative sums
    cb_sh  = cb_sum >>> 8;
    cr_sh  = cr_sum >>> 8;
    cb_val = cb_sh[PW-1:0] + ryuv_pkg::C_OFFSET;
    cr_val = cr_sh[PW-1:0] + ryuv_pkg::C_OFFSET;
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic [PW-1:0] out_luma_r;
  logic          out_chroma_r;
  logic [PW-1:0] out_cb_r;
  logic [PW-1:0] out_cr_r;
  logic          out_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_v_r) begin
      out_luma_r   <= y_val;
      out_chroma_r <= s1_chroma_r;
      out_cb_r     <= s1_chroma_r ? cb_val : '0;
      out_cr_r     <= s1_chroma_r ? cr_val : '0;
      out_end_r    <= s1_end_r;
    end
  end

  assign out_yuv.valid        = out_v_r;
  assign out_yuv.luma         = out_luma_r;
  assign out_yuv.chroma_valid = out_chroma_r;
  assign out_yuv.blue_diff    = out_cb_r;
  assign out_yuv.red_diff     = out_cr_r;
  assign out_yuv.frame_end    = out_end_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // the line store never sees a store and a fetch in the same cycle
  a_line_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(line_wr && line_rd))
    else $error("line store written and read in one cycle");

  // the last kept pixel always closes a 2x2 block
  a_end_chroma: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_end_r |-> out_chroma_r)
    else $error("frame end without chroma");

  // a held stage 1 blocks new transactions
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !adv |-> !in_pix.ready)
    else $error("input accepted while stage 1 is stalled");

  // a stalled stage 1 pixel is still there in the next cycle
  a_s1_keep: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !adv |=> s1_v_r && $stable(s1_pair_r))
    else $error("stage 1 lost a stalled pixel");

endmodule

@@ tb/sv/tb_rgb_to_yuv420_converter.sv @@
`timescale 1ns / 100ps

module tb_rgb_to_yuv420_converter;

  localparam int PIX_W      = ryuv_pkg::PIX_W;
  localparam int REG_W      = ryuv_pkg::REG_W;
  localparam int PADDR_W    = ryuv_pkg::PADDR_W;
  localparam int CFG_DATA_W = ryuv_pkg::CFG_DATA_W;
  localparam int COMP_W     = ryuv_pkg::COMP_W;
  localparam int PAIR_W     = ryuv_pkg::PAIR_W;

  // Block geometry, as built for this bench.
  localparam int MAX_WIDTH   = 4096;
  localparam int STORE_DEPTH = MAX_WIDTH / 2;

  // Cycles to let pass once the last expected sample has come out. The
  // pipeline is two stages deep; dropped pixels may still be in flight.
  localparam int DRAIN_CYCLES = 8;

  // Timeout. The slowest correct run is roughly 1.4k pixels, each held up by
  // the worst input gap, the worst output stall and the pipeline, plus a
  // config pause and drain per phase with at most one phase per pixel;
  // allow several times that.
  localparam int CYCLE_LIMIT = 600_000;

  // Pixels to send in the random part; the directed table adds 24 more.
  localparam int RANDOM_ITEMS = 1326;

  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic             chroma_valid;
    logic [PIX_W-1:0] blue_diff;
    logic [PIX_W-1:0] red_diff;
    logic             frame_end;
  } yuv_sample_t;

  typedef enum logic [1:0] {
    ROW_PIXEL,
    ROW_SET_WIDTH,
    ROW_SET_HEIGHT
  } row_kind_t;

  // One row of the directed table: either a register write or a pixel. A
  // pixel row with known set carries its expected sample; all others are
  // checked against the conversion model below.
  typedef struct packed {
    row_kind_t        kind;
    logic [REG_W-1:0] value;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             known;
    yuv_sample_t      known_res;
  } stim_row_t;

  // Samples that can be read straight off the BT.601 formulas: black gives
  // luma 16, white gives 235, and any gray block gives neutral chroma 128.
  localparam yuv_sample_t NO_RESULT   = '0;
  localparam yuv_sample_t BLACK_Y     = '{8'd16, 1'b0, 8'd0, 8'd0, 1'b0};
  localparam yuv_sample_t WHITE_Y     = '{8'd235, 1'b0, 8'd0, 8'd0, 1'b0};
  localparam yuv_sample_t BLACK_BLOCK = '{8'd16, 1'b1, 8'd128, 8'd128, 1'b1};
  localparam yuv_sample_t WHITE_BLOCK = '{8'd235, 1'b1, 8'd128, 8'd128, 1'b1};

  localparam int NUM_DIRECTED = 30;

  stim_row_t directed_rows [NUM_DIRECTED] = '{
    // Straight out of reset (640x480): black, then white at the odd column.
    '{ROW_PIXEL, 13'd0, 8'd0, 8'd0, 8'd0, 1'b1, BLACK_Y},
    '{ROW_PIXEL, 13'd0, 8'd255, 8'd255, 8'd255, 1'b1, WHITE_Y},
    // Smallest frame with chroma: 2x2, every fourth pixel closes the frame block.
    '{ROW_SET_WIDTH, 13'd2, 8'd0, 8'd0, 8'd0, 1'b0, NO_RESULT},
    '{ROW_SET_HEIGHT, 13'd2, 8'd0, 8'd0, 8'd0, 1'b0, NO_RESULT},
    '{ROW_PIXEL, 13'd0, 8'd255, 8'd255, 8'd255, 1'b1, WHITE_Y},
    '{ROW_PIXEL, 13'd0, 8'd255, 8'd255, 8'd255, 1'b1, WHITE_Y},
    '{ROW_PIXEL, 13'd0, 8'd255, 8'd255, 8'd255, 1'b1, WHITE_Y},
    '{ROW_PIXEL, 13'd0, 8'd255, 8'd255, 8'd255, 1'b1, WHITE_BLOCK},
    '{ROW_PIXEL, 13'd0, 8'd0, 8'd0, 8'd0, 1'b1, BLACK_Y},
    '{ROW_PIXEL, 13'd0, 8'd0, 8'd0, 8'd0, 1'b1, BLACK_Y},
    '{ROW_PIXEL, 13'd0, 8'd0, 8'd0, 8'd0, 1'b1, BLACK_Y},
    '{ROW_PIXEL, 13'd0, 8'd0, 8'd0, 8'd0, 1'b1, BLACK_BLOCK},
    // Pure primaries in one block: negative chroma sums, truncating average.
    '{ROW_PIXEL, 13'd0, 8'd0, 8'd0, 8'd255, 1'b0, NO_RESULT},
    '{ROW_PIXEL, 13'd0, 8'd255, 8'd0, 8'd0, 1'b0, NO_RESULT},
    '{ROW_PIXEL, 13'd0, 8'd0, 8'd255, 8'd0, 1'b0, NO_RESULT},
    '{ROW_PIXEL, 13'd0, 8'd254, 8'd1, 8'd3, 1'b0, NO_RESULT},
    // Odd width: the third column of each line is consumed without output.
    '{ROW_SET_WIDTH, 13'd3, 8'd0, 8'd0, 8'd0, 1'b0, NO_RESULT},
    '{ROW_PIXEL, 13'd0, 8'h55, 8'hAA, 8'h55, 1'b0, NO_RESULT},
    '{ROW_PIXEL, 13'd0, 8'hAA, 8'h55, 8'hAA, 1'b0, NO_RESULT},
    '{ROW_PIXEL, 13'd0, 8'hFF, 8'hFF, 8'hFF, 1'b0, NO_RESULT},
    '{ROW_PIXEL, 13'd0, 8'h0F, 8'hF0, 8'h3C, 1'b0, NO_RESULT},
    '{ROW_PIXEL, 13'd0, 8'hF0, 8'h0F, 8'hC3, 1'b0, NO_RESULT},
    '{ROW_PIXEL, 13'd0, 8'h00, 8'h00, 8'h00, 1'b0, NO_RESULT},
    // Zero width counts as one column, cropped to nothing: no output.
    '{ROW_SET_WIDTH, 13'd0, 8'd0, 8'd0, 8'd0, 1'b0, NO_RESULT},
    '{ROW_PIXEL, 13'd0, 8'd12, 8'd34, 8'd56, 1'b0, NO_RESULT},
    '{ROW_PIXEL, 13'd0, 8'd78, 8'd90, 8'd21, 1'b0, NO_RESULT},
    // All-ones register values saturate to the largest frame.
    '{ROW_SET_WIDTH, 13'h1FFF, 8'd0, 8'd0, 8'd0, 1'b0, NO_RESULT},
    '{ROW_SET_HEIGHT, 13'h1FFF, 8'd0, 8'd0, 8'd0, 1'b0, NO_RESULT},
    '{ROW_PIXEL, 13'd0, 8'd200, 8'd100, 8'd50, 1'b0, NO_RESULT},
    '{ROW_PIXEL, 13'd0, 8'd50, 8'd100, 8'd200, 1'b0, NO_RESULT}
  };

  logic clk;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [PADDR_W-1:0]    cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  ryuv_pix_if in_pix ();
  ryuv_yuv_if out_yuv ();

  rgb_to_yuv420_converter #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_pix     (in_pix),
    .out_yuv    (out_yuv),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Conversion model state: registers, raster position, the held even-column
  // pixel and the line of pair sums. Packing is R low, then G, then B.
  logic [REG_W-1:0]  model_width  = ryuv_pkg::FRAME_WIDTH_RST;
  logic [REG_W-1:0]  model_height = ryuv_pkg::FRAME_HEIGHT_RST;
  int unsigned       pix_col      = 0;
  int unsigned       pix_row      = 0;
  logic [PAIR_W-1:0] pair_hold    = '0;
  logic [PAIR_W-1:0] pair_sums [STORE_DEPTH] = '{default: '0};

  yuv_sample_t expected_yuv_q [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned sent_random    = 0;
  bit          no_idle        = 1'b0;

  // 12 ns clock.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Zero and oversize register values map onto the usable frame range.
  function automatic int unsigned clamp_size(input logic [REG_W-1:0] value,
                                             input int unsigned limit);
    int unsigned size;
    size = value;
    if (size == 0) size = 1;
    if (size > limit) size = limit;
    return size;
  endfunction

  // Run one pixel through the model; return 1 when it yields a sample.
  function automatic bit convert_pixel(input logic [PIX_W-1:0] red,
                                       input logic [PIX_W-1:0] green,
                                       input logic [PIX_W-1:0] blue,
                                       output yuv_sample_t res);
    int unsigned       ri, gi, bi, w, h, wk, hk, idx, pr, pg, pb;
    int                ar, ag, ab, cb, cr;
    logic [PAIR_W-1:0] stored;
    bit                kept;
    ri = red;
    gi = green;
    bi = blue;
    w  = clamp_size(model_width, MAX_WIDTH);
    h  = clamp_size(model_height, ryuv_pkg::HEIGHT_LIMIT);
    wk = w & ~32'd1;
    hk = h & ~32'd1;
    kept = (pix_col < wk) && (pix_row < hk);
    res = '0;
    if (kept) begin
      res.luma = PIX_W'(((66 * ri + 129 * gi + 25 * bi + 128) >> 8) + 16);
      idx = pix_col >> 1;
      if (pix_col[0] == 1'b0) begin
        pair_hold = {COMP_W'(bi), COMP_W'(gi), COMP_W'(ri)};
      end else begin
        pr = pair_hold[COMP_W-1:0] + ri;
        pg = pair_hold[2*COMP_W-1:COMP_W] + gi;
        pb = pair_hold[3*COMP_W-1:2*COMP_W] + bi;
        if (pix_row[0] == 1'b0) begin
          pair_sums[idx] = {COMP_W'(pb), COMP_W'(pg), COMP_W'(pr)};
        end else begin
          // Average the 2x2 block, then shift the signed sums arithmetically.
          stored = pair_sums[idx];
          ar = int'((pr + stored[COMP_W-1:0]) >> 2);
          ag = int'((pg + stored[2*COMP_W-1:COMP_W]) >> 2);
          ab = int'((pb + stored[3*COMP_W-1:2*COMP_W]) >> 2);
          cb = ((-38 * ar - 74 * ag + 112 * ab + 128) >>> 8) + 128;
          cr = ((112 * ar - 94 * ag - 18 * ab + 128) >>> 8) + 128;
          res.chroma_valid = 1'b1;
          res.blue_diff    = cb[PIX_W-1:0];
          res.red_diff     = cr[PIX_W-1:0];
        end
      end
      res.frame_end = (pix_col == wk - 1) && (pix_row == hk - 1);
    end
    pix_col++;
    if (pix_col >= w) begin
      pix_col = 0;
      pix_row++;
      if (pix_row >= h) pix_row = 0;
    end
    return kept;
  endfunction

  function automatic logic [PIX_W-1:0] rand_component();
    if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  // Send one pixel transaction. Entered and left at a falling edge; valid
  // stays high on exit so that a back-to-back pixel needs no toggle.
  task automatic send_pixel(input logic [PIX_W-1:0] red,
                            input logic [PIX_W-1:0] green,
                            input logic [PIX_W-1:0] blue,
                            input logic known,
                            input yuv_sample_t known_res);
    int unsigned gap;
    yuv_sample_t predicted;
    bit          produced;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_pix.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_pix.valid = 1'b1;
    in_pix.red   = red;
    in_pix.green = green;
    in_pix.blue  = blue;
    do @(posedge clk); while (!in_pix.ready);
    produced = convert_pixel(red, green, blue, predicted);
    if (known) expected_yuv_q.push_back(known_res);
    else if (produced) expected_yuv_q.push_back(predicted);
    @(negedge clk);
  endtask

  // Drop valid, wait for every expected sample, then let the pipeline drain.
  task automatic wait_idle();
    in_pix.valid = 1'b0;
    while (expected_yuv_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // APB write: setup, then access; the register takes it at the access edge.
  // Any write restarts the frame, so rewind the model's raster position.
  task automatic write_register(input logic [PADDR_W-1:0] addr,
                                input logic [REG_W-1:0] value);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = addr;
    // Junk above the register width must be ignored.
    cfg_pwdata  = ($urandom() & ~32'h1FFF) | CFG_DATA_W'(value);
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == ryuv_pkg::ADDR_FRAME_WIDTH) model_width = value;
    else model_height = value;
    pix_col   = 0;
    pix_row   = 0;
    pair_hold = '0;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // One random phase: pick a frame size, write one or both registers, then
  // stream pixels. Small frames get whole frames plus sometimes a partial one
  // cut short by the next write; big frames get a short burst.
  task automatic run_phase();
    logic [REG_W-1:0] w_val, h_val;
    int unsigned      sel, which, frame, count;
    which = $urandom_range(0, 3);
    sel = $urandom_range(0, 15);
    case (sel)
      0: begin
        w_val = ($urandom_range(0, 1) != 0) ? 13'd0 : REG_W'($urandom_range(1, 6));
        h_val = (w_val == 0) ? REG_W'($urandom_range(1, 6)) : 13'd0;
        which = 2;
      end
      1: begin
        w_val = REG_W'($urandom_range(4097, 8191));
        h_val = REG_W'($urandom_range(1, 4));
      end
      2: begin
        w_val = REG_W'($urandom_range(1, 6));
        h_val = REG_W'($urandom_range(4097, 8191));
      end
      3: begin
        w_val = REG_W'($urandom_range(0, 8191));
        h_val = REG_W'($urandom_range(0, 8191));
      end
      default: begin
        w_val = REG_W'($urandom_range(1, 12));
        h_val = REG_W'($urandom_range(1, 8));
      end
    endcase
    wait_idle();
    no_idle = ($urandom_range(0, 4) == 0);
    if (which != 1) write_register(ryuv_pkg::ADDR_FRAME_WIDTH, w_val);
    if (which != 0) write_register(ryuv_pkg::ADDR_FRAME_HEIGHT, h_val);
    frame = clamp_size(model_width, MAX_WIDTH)
          * clamp_size(model_height, ryuv_pkg::HEIGHT_LIMIT);
    if (frame <= 160) begin
      count = frame * $urandom_range(1, 3);
      if ($urandom_range(0, 3) == 0) count += $urandom_range(1, frame);
    end else begin
      count = $urandom_range(1, 48);
    end
    if (count > RANDOM_ITEMS - sent_random) count = RANDOM_ITEMS - sent_random;
    repeat (count) begin
      send_pixel(rand_component(), rand_component(), rand_component(), 1'b0, NO_RESULT);
      sent_random++;
    end
  endtask

  // Hard stop if the run hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Output side: per sample, hold ready low for a random stall, then raise
  // it until a transaction completes. Ready stays high when the stall is 0.
  initial begin : yuv_sink
    int unsigned stall;
    out_yuv.ready = 1'b0;
    wait (rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 17);
      if (stall != 0) begin
        out_yuv.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_yuv.ready = 1'b1;
      do @(posedge clk); while (!out_yuv.valid);
      @(negedge clk);
    end
  end

  // Compare every output transaction with the oldest expected sample.
  always @(posedge clk) begin : yuv_check
    yuv_sample_t got;
    yuv_sample_t want;
    if (rst_n && out_yuv.valid && out_yuv.ready) begin
      got = '{out_yuv.luma, out_yuv.chroma_valid, out_yuv.blue_diff, out_yuv.red_diff,
              out_yuv.frame_end};
      if (expected_yuv_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected sample: luma=%0d cv=%0b cb=%0d cr=%0d fe=%0b",
                   got.luma, got.chroma_valid, got.blue_diff, got.red_diff, got.frame_end);
      end else begin
        want = expected_yuv_q.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $write("sample mismatch: expected luma=%0d cv=%0b cb=%0d cr=%0d fe=%0b,",
                   want.luma, want.chroma_valid, want.blue_diff, want.red_diff,
                   want.frame_end);
            $display(" got luma=%0d cv=%0b cb=%0d cr=%0d fe=%0b",
                     got.luma, got.chroma_valid, got.blue_diff, got.red_diff,
                     got.frame_end);
          end
        end
      end
    end
  end

  // Main sequence: reset, directed table, random phases, drain, verdict.
  initial begin : stimulus
    rst_n        = 1'b0;
    in_pix.valid = 1'b0;
    in_pix.red   = '0;
    in_pix.green = '0;
    in_pix.blue  = '0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    // Hold reset, then release it at a falling edge.
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Walk the directed table; registers change only with the block idle.
    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_PIXEL: begin
          send_pixel(directed_rows[i].red, directed_rows[i].green, directed_rows[i].blue,
                     directed_rows[i].known, directed_rows[i].known_res);
        end
        ROW_SET_WIDTH: begin
          wait_idle();
          write_register(ryuv_pkg::ADDR_FRAME_WIDTH, directed_rows[i].value);
        end
        default: begin
          wait_idle();
          write_register(ryuv_pkg::ADDR_FRAME_HEIGHT, directed_rows[i].value);
        end
      endcase
    end

    // Random phases until the pixel budget is spent.
    while (sent_random < RANDOM_ITEMS) begin
      run_phase();
    end

    wait_idle();
    if (mismatch_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/ryuv_pkg.sv
hdl/ryuv_pix_if.sv
hdl/ryuv_yuv_if.sv
hdl/ryuv_ram.sv
hdl/rgb_to_yuv420_converter.sv
tb/sv/tb_rgb_to_yuv420_converter.sv
